// ===== design/delta_id_offset_table_decoder_macros.svh =====
// assertion helpers for the table decoder
`ifndef DELTA_ID_OFFSET_TABLE_DECODER_MACROS_SVH
`define DELTA_ID_OFFSET_TABLE_DECODER_MACROS_SVH

// property holds at every edge out of reset
`define DIOT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the following cycle
`define DIOT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/diot_pkg.sv =====
package diot_pkg;

  // header and entry phases
  localparam logic [3:0] PhFormat  = 4'd0;
  localparam logic [3:0] PhVersion = 4'd1;
  localparam logic [3:0] PhNamelen = 4'd2;
  localparam logic [3:0] PhName    = 4'd3;
  localparam logic [3:0] PhPtrsize = 4'd4;
  localparam logic [3:0] PhCount   = 4'd5;
  localparam logic [3:0] PhType    = 4'd6;
  localparam logic [3:0] PhId      = 4'd7;
  localparam logic [3:0] PhOff     = 4'd8;
  localparam logic [3:0] PhDone    = 4'd9;

  // status codes
  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StBadFormat = 3'd1;
  localparam logic [2:0] StZeroName  = 3'd2;
  localparam logic [2:0] StZeroPtr   = 3'd3;
  localparam logic [2:0] StBadId     = 3'd4;
  localparam logic [2:0] StTrunc     = 3'd5;

  localparam int unsigned DataW = 64;
  localparam int unsigned DivW  = 32;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

  // field length in bytes per code
  function automatic logic [3:0] code_len(input logic [2:0] code);
    logic [3:0] r;
    unique case (code)
      3'd0: r = 4'd8;
      3'd1: r = 4'd0;
      3'd2, 3'd3: r = 4'd1;
      3'd4, 3'd5, 3'd6: r = 4'd2;
      default: r = 4'd4;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] apply_code(input logic [2:0] code, input logic [63:0] raw,
                                             input logic [63:0] base);
    logic [63:0] r;
    unique case (code)
      3'd1: r = base + 64'd1;
      3'd2, 3'd4: r = base + raw;
      3'd3, 3'd5: r = base - raw;
      default: r = raw;
    endcase
    return r;
  endfunction

endpackage

// ===== design/diot_divider.sv =====
// restoring divider, one quotient bit per cycle
module diot_divider #(
  parameter int unsigned DataW = diot_pkg::DataW,
  parameter int unsigned DivW  = diot_pkg::DivW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DataW-1:0]    dividend_i,
  input  logic [DivW-1:0]     divisor_i,
  output logic                busy_o,
  output logic                done_o,
  output logic [DataW-1:0]    quotient_o
);
  localparam int unsigned CntW = $clog2(DataW + 1);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic [DivW:0]    rem_q, rem_d;
  logic [DivW-1:0]  dvs_q, dvs_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DivW:0]    trial;

  // load on start, otherwise one shift and subtract step
  always_comb begin
    cnt_d = cnt_q; quo_d = quo_q; rem_d = rem_q; dvs_d = dvs_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[DivW-1:0], quo_q[DataW-1]};
    if (start_i) begin
      quo_d = dividend_i; rem_d = '0; dvs_d = divisor_i;
      cnt_d = CntW'(DataW); busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DataW-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; busy_q <= 1'b0; done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d; busy_q <= busy_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

`include "delta_id_offset_table_decoder_macros.svh"
  `DIOT_ASSERT(a_div_exclusive, !(busy_q && done_q), "divider busy and done together")
  `DIOT_ASSERT_NEXT(a_div_start, start_i, busy_q, "divider did not start")
  `DIOT_ASSERT(a_div_cnt, busy_q || cnt_q == '0, "divider count left over")
endmodule

// ===== design/delta_id_offset_table_decoder.sv =====
// channel | dir | tdata (low bit up)                       | tuser       | tlast
// s_axis  | in  | data_byte[7:0]                           | -           | last_byte
// m_axis  | out | entry_id[63:0], entry_offset[127:64],    | result_kind | -
//         |     | status[130:128], unit_size[162:131]      |             |
// a header byte is taken by the sequencer alone; a byte that closes a plain entry goes
// through the sequencer and the output load; one that closes a pointer-unit entry goes
// through the serial 64-bit divider, applies the code, takes the 64x32 multiply in 32x32
// halves, then the output load. a last byte adds the status beat.
// the sequencer waits while the output register holds an untaken beat. reset is
// asynchronous, active low, and brings the block to the format word of a fresh buffer.
module delta_id_offset_table_decoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // data_byte[7:0]
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [167:0] m_axis_tdata,  // entry_id, entry_offset, status, unit_size
  output logic         m_axis_tuser   // result_kind
);
  typedef enum logic [5:0] {
    SIdle = 6'b000001, SDiv = 6'b000010, SMulLo = 6'b000100,
    SMulHi = 6'b001000, SOut = 6'b010000, SStat = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [3:0]  phase_q, phase_d, bidx_q, bidx_d;
  logic [63:0] fld_q, fld_d, pid_q, pid_d, ppos_q, ppos_d, cid_q, cid_d;
  logic [31:0] skip_q, skip_d, psz_q, psz_d, left_q, left_d;
  logic [7:0]  tc_q, tc_d;
  logic [2:0]  err_q, err_d;
  logic        last_q, last_d;
  logic [63:0] raw_q, raw_d, base_q, base_d, off_q, off_d, mlo_q, mlo_d;
  logic        ov_q, ov_d, okind_q, okind_d;
  logic [167:0] odat_q, odat_d;
  diot_pkg::div_req_t req;
  diot_pkg::div_rsp_t rsp;

  diot_divider #(.DataW(diot_pkg::DataW), .DivW(diot_pkg::DivW)) u_div (
    .clk_i, .rst_ni, .start_i(req.start), .dividend_i(req.dividend), .divisor_i(req.divisor),
    .busy_o(rsp.busy), .done_o(rsp.done), .quotient_o(rsp.quotient));

  assign s_axis_tready = (state_q == SIdle);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = odat_q;
  assign m_axis_tuser  = okind_q;

  // sequencer and byte parser
  always_comb begin
    logic [63:0] acc, o, ob;
    logic [31:0] v;
    logic [3:0]  ni, ln;
    logic [2:0]  hc, st;
    logic        fin;
    state_d = state_q; phase_d = phase_q; bidx_d = bidx_q; fld_d = fld_q;
    pid_d = pid_q; ppos_d = ppos_q; cid_d = cid_q; skip_d = skip_q; psz_d = psz_q;
    left_d = left_q; tc_d = tc_q; err_d = err_q; last_d = last_q;
    raw_d = raw_q; base_d = base_q; off_d = off_q; mlo_d = mlo_q;
    ov_d = ov_q; okind_d = okind_q; odat_d = odat_q;
    req.start = 1'b0; req.dividend = ppos_q; req.divisor = psz_q;
    acc = fld_q | (64'(s_axis_tdata) << {bidx_q[2:0], 3'b000});
    ni = bidx_q + 4'd1;
    v = acc[31:0];
    fin = 1'b0; ln = '0; hc = '0; o = '0; ob = '0; st = '0;
    if (ov_q && m_axis_tready) ov_d = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (s_axis_tvalid) begin
          last_d = s_axis_tlast;
          state_d = s_axis_tlast ? SStat : SIdle;
          if (err_q == diot_pkg::StOk && phase_q != diot_pkg::PhDone) begin
            unique case (phase_q)
              diot_pkg::PhFormat, diot_pkg::PhNamelen, diot_pkg::PhPtrsize,
              diot_pkg::PhCount: begin
                fld_d = acc; bidx_d = ni;
                if (ni >= 4'd4) begin
                  bidx_d = '0; fld_d = '0;
                  if (phase_q == diot_pkg::PhFormat) begin
                    if (v != 32'd1 && v != 32'd2) err_d = diot_pkg::StBadFormat;
                    else phase_d = diot_pkg::PhVersion;
                  end else if (phase_q == diot_pkg::PhNamelen) begin
                    if (v == '0) err_d = diot_pkg::StZeroName;
                    else begin skip_d = v; phase_d = diot_pkg::PhName; end
                  end else if (phase_q == diot_pkg::PhPtrsize) begin
                    psz_d = v;
                    if (v == '0) err_d = diot_pkg::StZeroPtr;
                    else phase_d = diot_pkg::PhCount;
                  end else begin
                    left_d = v;
                    phase_d = (v != '0) ? diot_pkg::PhType : diot_pkg::PhDone;
                  end
                end
              end
              diot_pkg::PhVersion: begin
                if (bidx_q >= 4'd15) begin bidx_d = '0; phase_d = diot_pkg::PhNamelen; end
                else bidx_d = ni;
              end
              diot_pkg::PhName: begin
                skip_d = skip_q - 32'd1;
                if (skip_q == 32'd1) phase_d = diot_pkg::PhPtrsize;
              end
              diot_pkg::PhType: begin
                tc_d = s_axis_tdata; bidx_d = '0; fld_d = '0;
                hc = s_axis_tdata[6:4];
                if (s_axis_tdata[3]) err_d = diot_pkg::StBadId;
                else if (diot_pkg::code_len(s_axis_tdata[2:0]) == '0) begin
                  cid_d = pid_q + 64'd1;
                  if (diot_pkg::code_len(hc) == '0) begin fin = 1'b1; raw_d = '0; end
                  else phase_d = diot_pkg::PhOff;
                end else phase_d = diot_pkg::PhId;
              end
              diot_pkg::PhId: begin
                fld_d = acc; bidx_d = ni;
                hc = tc_q[6:4];
                if (ni >= diot_pkg::code_len(tc_q[2:0])) begin
                  cid_d = diot_pkg::apply_code(tc_q[2:0], acc, pid_q);
                  bidx_d = '0; fld_d = '0;
                  if (diot_pkg::code_len(hc) == '0) begin fin = 1'b1; raw_d = '0; end
                  else phase_d = diot_pkg::PhOff;
                end
              end
              diot_pkg::PhOff: begin
                fld_d = acc; bidx_d = ni;
                ln = diot_pkg::code_len(tc_q[6:4]);
                if (ni >= ln) begin fin = 1'b1; raw_d = acc; end
              end
              default: ;
            endcase
            // entry complete: plain path here, pointer units via divider
            if (fin) begin
              left_d = left_q - 32'd1;
              phase_d = (left_q != 32'd1) ? diot_pkg::PhType : diot_pkg::PhDone;
              if (phase_q == diot_pkg::PhType) tc_d = s_axis_tdata;
              if (phase_q == diot_pkg::PhType ? s_axis_tdata[7] : tc_q[7]) begin
                req.start = 1'b1; state_d = SDiv;
              end else begin
                o = diot_pkg::apply_code(phase_q == diot_pkg::PhType ? s_axis_tdata[6:4]
                                         : tc_q[6:4], raw_d, ppos_q);
                off_d = o; state_d = SOut;
              end
            end
          end
        end
      end
      SDiv: begin
        if (rsp.done) begin
          ob = diot_pkg::apply_code(tc_q[6:4], raw_q, rsp.quotient);
          base_d = ob; state_d = SMulLo;
        end
      end
      SMulLo: begin
        mlo_d = 64'(base_q[31:0]) * 64'(psz_q);
        state_d = SMulHi;
      end
      SMulHi: begin
        off_d = mlo_q + {base_q[63:32] * psz_q, 32'd0};
        state_d = SOut;
      end
      SOut: begin
        if (!ov_q) begin
          ov_d = 1'b1; okind_d = 1'b0;
          odat_d = {5'd0, 32'd0, 3'd0, off_q, cid_q};
          pid_d = cid_q; ppos_d = off_q;
          state_d = last_q ? SStat : SIdle;
        end
      end
      SStat: begin
        if (!ov_q || m_axis_tready) begin
          st = (err_q != diot_pkg::StOk) ? err_q
             : ((phase_q == diot_pkg::PhDone) ? diot_pkg::StOk : diot_pkg::StTrunc);
          ov_d = 1'b1; okind_d = 1'b1;
          odat_d = {5'd0, psz_q, st, 64'd0, 64'd0};
          state_d = SIdle; phase_d = diot_pkg::PhFormat; bidx_d = '0; fld_d = '0;
          skip_d = '0; psz_d = '0; left_d = '0; tc_d = '0; pid_d = '0; ppos_d = '0;
          cid_d = '0; err_d = diot_pkg::StOk; last_d = 1'b0;
        end
      end
      default: state_d = SIdle;
    endcase
    if (state_q == SOut && ov_q && m_axis_tready) begin
      ov_d = 1'b1; okind_d = 1'b0;
      odat_d = {5'd0, 32'd0, 3'd0, off_q, cid_q};
      pid_d = cid_q; ppos_d = off_q;
      state_d = last_q ? SStat : SIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; phase_q <= diot_pkg::PhFormat; bidx_q <= '0; fld_q <= '0;
      pid_q <= '0; ppos_q <= '0; cid_q <= '0; skip_q <= '0; psz_q <= '0; left_q <= '0;
      tc_q <= '0; err_q <= '0; last_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; phase_q <= phase_d; bidx_q <= bidx_d; fld_q <= fld_d;
      pid_q <= pid_d; ppos_q <= ppos_d; cid_q <= cid_d; skip_q <= skip_d; psz_q <= psz_d;
      left_q <= left_d; tc_q <= tc_d; err_q <= err_d; last_q <= last_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q <= raw_d; base_q <= base_d; off_q <= off_d; mlo_q <= mlo_d;
    okind_q <= okind_d; odat_q <= odat_d;
  end

`include "delta_id_offset_table_decoder_macros.svh"
  `DIOT_ASSERT(a_ready_idle, !s_axis_tready || state_q == SIdle, "ready outside idle")
  `DIOT_ASSERT(a_div_only_sdiv, !rsp.busy || state_q == SDiv, "divider busy out of sequence")
  `DIOT_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata),
    "output beat dropped while stalled")
endmodule
